>>> hdl/ptq_pkg.sv
`timescale 1ns / 1ps
// ptq_pkg: shared types and codes of the per-tick quota throttle queue.
// No dependencies; used by ptq_mem, ptq_ctrl, ptq_out and the top level.

package ptq_pkg;

  // Fixed field widths
  localparam int unsigned TAG_W     = 32;
  localparam int unsigned OWNER_W   = 16;
  localparam int unsigned QUOTA_W   = 16;
  localparam int unsigned RMV_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUOTA    = 2'd1;
  localparam logic                 THROTTLE_RST = 1'b1;
  localparam logic [QUOTA_W-1:0]   QUOTA_RST    = 16'd100;

  typedef enum logic [1:0] {
    CMD_ENQ_BACK  = 2'd0,
    CMD_ENQ_FRONT = 2'd1,
    CMD_TICK      = 2'd2,
    CMD_PURGE     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_RELEASED = 2'd1,
    KIND_REJECTED = 2'd2,
    KIND_REPORT   = 2'd3
  } kind_e;

  // One queue slot
  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [TAG_W-1:0]   tag;
  } slot_t;

  // One result item
  typedef struct packed {
    kind_e              kind;
    logic [TAG_W-1:0]   tag;
    logic [OWNER_W-1:0] owner;
    logic [RMV_W-1:0]   removed;
    logic               last;
  } res_t;

endpackage

>>> hdl/ptq_mem.sv
`timescale 1ns / 1ps
// ptq_mem: slot storage of the queue, one write and one read port,
// read data registered. Depends on ptq_pkg.

module ptq_mem #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] waddr_i,
  input  ptq_pkg::slot_t                 wdata_i,
  input  logic                           re_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] raddr_i,
  output ptq_pkg::slot_t                 rdata_o
);

  ptq_pkg::slot_t mem_q [QUEUE_DEPTH];
  ptq_pkg::slot_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/ptq_ctrl.sv
`timescale 1ns / 1ps
// ptq_ctrl: queue pointers and the sequencer for enqueue, tick and purge.
// Drives the slot memory ports and pushes result items. Depends on ptq_pkg.

module ptq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ptq_pkg::cmd_e                  in_cmd_i,
  input  logic [ptq_pkg::TAG_W-1:0]      in_tag_i,
  input  logic [ptq_pkg::OWNER_W-1:0]    in_owner_i,
  // configuration
  input  logic                           throttle_i,
  input  logic [ptq_pkg::QUOTA_W-1:0]    quota_i,
  // result items
  input  logic                           res_room_i,
  output logic                           res_valid_o,
  output ptq_pkg::res_t                  res_o,
  // slot memory
  output logic                           mem_we_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] mem_waddr_o,
  output ptq_pkg::slot_t                 mem_wdata_o,
  output logic                           mem_re_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] mem_raddr_o,
  input  ptq_pkg::slot_t                 mem_rdata_i
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_TICK_RD   = 3'd1;
  localparam logic [2:0] ST_TICK_EMIT = 3'd2;
  localparam logic [2:0] ST_PURGE     = 3'd3;

  logic [2:0]                   state_q, state_d;
  logic [PTR_W-1:0]             head_q, head_d;
  logic [CNT_W-1:0]             occ_q, occ_d;
  logic [ptq_pkg::QUOTA_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]             idx_q, idx_d;
  logic [CNT_W-1:0]             kept_q, kept_d;
  logic [CNT_W-1:0]             rmv_q, rmv_d;
  logic                         rd_pend_q, rd_pend_d;
  logic [ptq_pkg::OWNER_W-1:0]  powner_q, powner_d;

  logic             accept;
  logic             tick_last;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] head_front;

  // Circular slot of (base + off), off never beyond the depth
  function automatic logic [PTR_W-1:0] slot_at(input logic [PTR_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  assign head_inc   = slot_at(head_q, CNT_W'(1));
  assign head_front = (head_q == '0) ? PTR_W'(QUEUE_DEPTH - 1) : head_q - 1'b1;
  assign tick_last  = (rem_q == ptq_pkg::QUOTA_W'(1)) || (occ_q == CNT_W'(1));
  assign accept     = in_valid_i && in_ready_o;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    occ_d       = occ_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    kept_d      = kept_q;
    rmv_d       = rmv_q;
    rd_pend_d   = 1'b0;
    powner_d    = powner_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = head_q;
    mem_wdata_o = {in_owner_i, in_tag_i};
    mem_re_o    = 1'b0;
    mem_raddr_o = head_q;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = res_room_i;
        if (accept) begin
          case (in_cmd_i)
            ptq_pkg::CMD_ENQ_BACK, ptq_pkg::CMD_ENQ_FRONT: begin
              res_valid_o = 1'b1;
              res_o.last  = 1'b1;
              if (!throttle_i) begin
                // pass straight through
                res_o.kind  = ptq_pkg::KIND_RELEASED;
                res_o.tag   = in_tag_i;
                res_o.owner = in_owner_i;
              end else if (occ_q == CNT_W'(QUEUE_DEPTH)) begin
                res_o.kind = ptq_pkg::KIND_REJECTED;
              end else begin
                res_o.kind = ptq_pkg::KIND_ACCEPTED;
                mem_we_o   = 1'b1;
                occ_d      = occ_q + 1'b1;
                if (in_cmd_i == ptq_pkg::CMD_ENQ_FRONT) begin
                  head_d      = head_front;
                  mem_waddr_o = head_front;
                end else begin
                  mem_waddr_o = slot_at(head_q, occ_q);
                end
              end
            end
            ptq_pkg::CMD_TICK: begin
              if ((occ_q == '0) || (throttle_i && (quota_i == '0))) begin
                // nothing to release
                res_valid_o = 1'b1;
                res_o.kind  = ptq_pkg::KIND_REPORT;
                res_o.last  = 1'b1;
              end else begin
                rem_d   = throttle_i ? quota_i : ptq_pkg::QUOTA_W'(QUEUE_DEPTH);
                state_d = ST_TICK_RD;
              end
            end
            ptq_pkg::CMD_PURGE: begin
              idx_d    = '0;
              kept_d   = '0;
              rmv_d    = '0;
              powner_d = in_owner_i;
              state_d  = ST_PURGE;
            end
            default: begin
            end
          endcase
        end
      end

      ST_TICK_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = head_q;
        state_d     = ST_TICK_EMIT;
      end

      // Release the front entry and prefetch the next one
      ST_TICK_EMIT: begin
        if (res_room_i) begin
          res_valid_o = 1'b1;
          res_o.kind  = ptq_pkg::KIND_RELEASED;
          res_o.tag   = mem_rdata_i.tag;
          res_o.owner = mem_rdata_i.owner;
          res_o.last  = tick_last;
          head_d      = head_inc;
          occ_d       = occ_q - 1'b1;
          rem_d       = rem_q - 1'b1;
          if (tick_last) begin
            state_d = ST_IDLE;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = head_inc;
          end
        end
      end

      // Read offset idx while compacting the entry read last cycle
      ST_PURGE: begin
        if (rd_pend_q) begin
          if (mem_rdata_i.owner == powner_q) begin
            rmv_d = rmv_q + 1'b1;
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = slot_at(head_q, kept_q);
            mem_wdata_o = mem_rdata_i;
            kept_d      = kept_q + 1'b1;
          end
        end
        if (idx_q != occ_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = slot_at(head_q, idx_q);
          idx_d       = idx_q + 1'b1;
          rd_pend_d   = 1'b1;
        end else if (!rd_pend_q && res_room_i) begin
          res_valid_o   = 1'b1;
          res_o.kind    = ptq_pkg::KIND_REPORT;
          res_o.removed = ptq_pkg::RMV_W'(rmv_q);
          res_o.last    = 1'b1;
          occ_d         = kept_q;
          state_d       = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      occ_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      occ_q     <= occ_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  // Work registers of the current command
  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    idx_q    <= idx_d;
    kept_q   <= kept_d;
    rmv_q    <= rmv_d;
    powner_q <= powner_d;
  end

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_room_i)
    else $error("result pushed into full output buffer");

  a_rw_apart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && mem_re_o) |-> (mem_waddr_o != mem_raddr_o))
    else $error("compaction write hits the slot being read");

  a_tick_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK_EMIT) |-> (occ_q != '0))
    else $error("tick release from an empty queue");

endmodule

>>> hdl/ptq_out.sv
`timescale 1ns / 1ps
// ptq_out: two-entry output buffer of result items, so the sequencer keeps
// going while one item waits on the output. Depends on ptq_pkg.

module ptq_out (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ptq_pkg::res_t push_data_i,
  output logic          room_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output ptq_pkg::res_t m_data_o
);

  ptq_pkg::res_t ent_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          pop;

  assign room_o    = (cnt_q != 2'd2);
  assign m_valid_o = (cnt_q != 2'd0);
  assign m_data_o  = ent_q[rd_ptr_q];
  assign pop       = m_valid_o && m_ready_i;

  // Payload entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_ptr_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
    else $error("output buffer pointers disagree with count");

endmodule

>>> hdl/per_tick_quota_throttle_queue.sv
`timescale 1ns / 1ps
// Per-tick quota throttle queue: top level with configuration registers.
// Enqueue: result pushed on accept; one per cycle while the output buffer has room.
// Tick: TICK_RD, then TICK_EMIT releases one per cycle while the output has room.
// Remove by owner: one slot read per cycle, then a report of the removed count.
// Reset: queue empty, throttling on, quota 100; slot memory is not cleared.
// Depends on ptq_pkg, ptq_mem, ptq_ctrl, ptq_out.

module per_tick_quota_throttle_queue #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [47:0]                       s_axis_tdata,  // message_tag, owner_id
  input  logic [1:0]                        s_axis_tuser,  // command
  // result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [55:0]                       m_axis_tdata,  // out_tag, out_owner,
                                                           // removed_count, zero pad
  output logic [1:0]                        m_axis_tuser,  // result_kind
  output logic                              m_axis_tlast,  // last
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [ptq_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ptq_pkg::QUOTA_W-1:0]       cfg_data_i
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  logic                         throttle_q;
  logic [ptq_pkg::QUOTA_W-1:0]  quota_q;

  logic                 res_valid;
  logic                 res_room;
  ptq_pkg::res_t        res;
  ptq_pkg::res_t        out_res;

  logic                 mem_we;
  logic [PTR_W-1:0]     mem_waddr;
  ptq_pkg::slot_t       mem_wdata;
  logic                 mem_re;
  logic [PTR_W-1:0]     mem_raddr;
  ptq_pkg::slot_t       mem_rdata;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      throttle_q <= ptq_pkg::THROTTLE_RST;
      quota_q    <= ptq_pkg::QUOTA_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ptq_pkg::REG_THROTTLE) begin
        throttle_q <= cfg_data_i[0];
      end
      if (cfg_idx_i == ptq_pkg::REG_QUOTA) begin
        quota_q <= cfg_data_i;
      end
    end
  end

  ptq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (ptq_pkg::cmd_e'(s_axis_tuser)),
    .in_tag_i    (s_axis_tdata[31:0]),
    .in_owner_i  (s_axis_tdata[47:32]),
    .throttle_i  (throttle_q),
    .quota_i     (quota_q),
    .res_room_i  (res_room),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ptq_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ptq_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .room_o      (res_room),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (out_res)
  );

  // Pack the result item onto the stream
  assign m_axis_tdata = {1'b0, out_res.removed, out_res.owner, out_res.tag};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule
